// ----- design/brlt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the byte-range lock table.
// Used by the controller, the datapath and the top level; no dependencies.
package brlt_pkg;

    // Default table sizes
    localparam int LOCK_ENTRIES_DEF = 32;
    localparam int HANDLE_COUNT_DEF = 256;

    // Request field widths
    localparam int OWNER_W  = 16;
    localparam int HANDLE_W = 8;
    localparam int KEY_W    = 16;
    localparam int OFS_W    = 32;

    // Saturated end of region
    localparam logic [OFS_W-1:0] END_SAT = '1;

    // Request modes
    typedef enum logic [1:0] {
        MODE_ACCESS = 2'd0,
        MODE_LOCK   = 2'd1,
        MODE_UNLOCK = 2'd2,
        MODE_CLOSE  = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_VIOLATION = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WAIT,
        S_COMMIT,
        S_DONE
    } t_state;

    // One lock slot as stored in the table memory
    typedef struct packed {
        logic                used;
        logic [OFS_W-1:0]    start_ofs;
        logic [OFS_W-1:0]    end_ofs;
        logic [HANDLE_W-1:0] handle;
        logic [OWNER_W-1:0]  owner;
        logic [KEY_W-1:0]    file_key;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // Controller to datapath commands
    typedef struct packed {
        logic load;         // latch the request word
        logic clr_step;     // clear one slot, advance address
        logic scan_step;    // read one slot, advance address
        logic commit;       // write back the lock or unlock
        logic result_load;  // move the result into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic addr_last;    // address counter sits on the last slot
        logic quick;        // request answered without a table scan
        logic out_free;     // output register can take a result
    } t_sts;

endpackage

// ----- design/brlt_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module brlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/brlt_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the byte-range lock table.
// Depends on brlt_pkg; drives the datapath through t_cmd.
module brlt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  brlt_pkg::t_sts  i_sts,
    output brlt_pkg::t_cmd  o_cmd
);

    brlt_pkg::t_state r_state;
    brlt_pkg::t_state n_state;

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brlt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            brlt_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = brlt_pkg::S_IDLE;
                end
            end
            brlt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = brlt_pkg::S_DECODE;
                end
            end
            brlt_pkg::S_DECODE: begin
                if (i_sts.quick) begin
                    n_state = brlt_pkg::S_DONE;
                end else begin
                    n_state = brlt_pkg::S_SCAN;
                end
            end
            brlt_pkg::S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = brlt_pkg::S_WAIT;
                end
            end
            // last read word is evaluated here
            brlt_pkg::S_WAIT: begin
                n_state = brlt_pkg::S_COMMIT;
            end
            brlt_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = brlt_pkg::S_DONE;
            end
            brlt_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = brlt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = brlt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != brlt_pkg::S_IDLE);

endmodule

// ----- design/brlt_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the byte-range lock table: request registers, slot memory,
// scan evaluation and output register. Depends on brlt_pkg and brlt_ram.
module brlt_dpath #(
    parameter int LOCK_ENTRIES = brlt_pkg::LOCK_ENTRIES_DEF,
    parameter int HANDLE_COUNT = brlt_pkg::HANDLE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  brlt_pkg::t_cmd                i_cmd,
    output brlt_pkg::t_sts                o_sts,
    input  logic [1:0]                    i_mode,
    input  logic [brlt_pkg::OWNER_W-1:0]  i_owner,
    input  logic [brlt_pkg::HANDLE_W-1:0] i_handle,
    input  logic [brlt_pkg::KEY_W-1:0]    i_file_key,
    input  logic [brlt_pkg::OFS_W-1:0]    i_offset,
    input  logic [brlt_pkg::OFS_W-1:0]    i_length,
    input  logic                          i_raise_critical,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output logic [1:0]                    o_status,
    output logic                          o_critical_error
);

    localparam int IDX_W = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOCK_ENTRIES - 1);

    // Latched request
    brlt_pkg::t_mode               r_mode;
    logic [brlt_pkg::OWNER_W-1:0]  r_owner;
    logic [brlt_pkg::HANDLE_W-1:0] r_handle;
    logic [brlt_pkg::KEY_W-1:0]    r_key;
    logic [brlt_pkg::OFS_W-1:0]    r_start;
    logic [brlt_pkg::OFS_W-1:0]    r_end;
    logic                          r_crit_req;
    logic                          r_handle_oor;
    logic                          r_zero_len;

    // Scan state
    logic [IDX_W-1:0] r_addr;
    logic             r_rd_valid;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_conflict;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_match_found;
    logic [IDX_W-1:0] r_match_idx;

    // Output register
    logic       r_out_valid;
    logic [1:0] r_status;
    logic       r_crit;

    logic [brlt_pkg::OFS_W:0]   sum_full;
    logic [brlt_pkg::OFS_W-1:0] end_sat;
    brlt_pkg::t_slot            rd_slot;
    brlt_pkg::t_slot            lock_slot;
    logic                       any_owner;
    logic                       conflict_hit;
    logic                       free_hit;
    logic                       match_hit;
    logic                       close_hit;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    brlt_pkg::t_slot            ram_wdata;
    brlt_pkg::t_status          res_status;
    logic                       res_crit;

    // End of region, saturated on overflow
    assign sum_full = {1'b0, i_offset} + {1'b0, i_length};
    assign end_sat  = sum_full[brlt_pkg::OFS_W] ? brlt_pkg::END_SAT
                                                : sum_full[brlt_pkg::OFS_W-1:0];

    // Request word capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode       <= brlt_pkg::t_mode'(i_mode);
            r_owner      <= i_owner;
            r_handle     <= i_handle;
            r_key        <= i_file_key;
            r_start      <= i_offset;
            r_end        <= end_sat;
            r_crit_req   <= i_raise_critical;
            r_handle_oor <= (32'(i_handle) >= 32'(HANDLE_COUNT));
            r_zero_len   <= (end_sat == i_offset);
        end
    end

    // Slot address counter, shared by the clearing pass and the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.load) begin
            r_addr <= '0;
        end else if (i_cmd.clr_step || i_cmd.scan_step) begin
            r_addr <= (r_addr == LAST_IDX) ? '0 : r_addr + 1'b1;
        end
    end

    // Read pipeline tag: slot data arrives in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
    end

    // Per-slot tests on the word just read
    assign any_owner    = (r_mode == brlt_pkg::MODE_LOCK) || (r_owner == '0);
    assign conflict_hit = r_rd_valid && rd_slot.used
                          && (any_owner || rd_slot.owner != r_owner)
                          && (rd_slot.file_key == r_key)
                          && (r_start < rd_slot.end_ofs)
                          && (rd_slot.start_ofs < r_end);
    assign free_hit     = r_rd_valid && !rd_slot.used;
    assign match_hit    = r_rd_valid && rd_slot.used
                          && (rd_slot.owner == r_owner)
                          && (rd_slot.handle == r_handle)
                          && (rd_slot.start_ofs == r_start)
                          && (rd_slot.end_ofs == r_end);
    assign close_hit    = r_rd_valid && (r_mode == brlt_pkg::MODE_CLOSE)
                          && rd_slot.used && (rd_slot.handle == r_handle);

    // Scan flags: any conflict, first free slot, first exact match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_conflict    <= 1'b0;
            r_free_found  <= 1'b0;
            r_match_found <= 1'b0;
        end else begin
            if (conflict_hit) begin
                r_conflict <= 1'b1;
            end
            if (free_hit && !r_free_found) begin
                r_free_found <= 1'b1;
            end
            if (match_hit && !r_match_found) begin
                r_match_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (free_hit && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
        if (match_hit && !r_match_found) begin
            r_match_idx <= r_rd_idx;
        end
    end

    // New lock entry
    always_comb begin
        lock_slot.used      = 1'b1;
        lock_slot.start_ofs = r_start;
        lock_slot.end_ofs   = r_end;
        lock_slot.handle    = r_handle;
        lock_slot.owner     = r_owner;
        lock_slot.file_key  = r_key;
    end

    // Write port: clearing pass, commit, or close-handle frees during scan
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        priority if (i_cmd.clr_step) begin
            ram_we = 1'b1;
        end else if (i_cmd.commit) begin
            if (r_mode == brlt_pkg::MODE_LOCK && !r_conflict && r_free_found) begin
                ram_we    = 1'b1;
                ram_waddr = r_free_idx;
                ram_wdata = lock_slot;
            end else if (r_mode == brlt_pkg::MODE_UNLOCK && r_match_found) begin
                ram_we    = 1'b1;
                ram_waddr = r_match_idx;
            end
        end else if (close_hit) begin
            ram_we    = 1'b1;
            ram_waddr = r_rd_idx;
        end else begin
            ram_we = 1'b0;
        end
    end

    brlt_ram #(
        .WIDTH (brlt_pkg::SLOT_W),
        .DEPTH (LOCK_ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_addr),
        .o_rdata (rd_slot)
    );

    // Result of the request
    always_comb begin
        res_status = brlt_pkg::ST_OK;
        res_crit   = 1'b0;
        if (r_handle_oor) begin
            res_status = (r_mode == brlt_pkg::MODE_CLOSE) ? brlt_pkg::ST_OK
                                                          : brlt_pkg::ST_VIOLATION;
        end else if (r_zero_len && r_mode != brlt_pkg::MODE_CLOSE) begin
            res_status = brlt_pkg::ST_OK;
        end else begin
            unique case (r_mode)
                brlt_pkg::MODE_ACCESS: begin
                    res_status = r_conflict ? brlt_pkg::ST_VIOLATION : brlt_pkg::ST_OK;
                    res_crit   = r_conflict && r_crit_req;
                end
                brlt_pkg::MODE_LOCK: begin
                    if (r_conflict) begin
                        res_status = brlt_pkg::ST_VIOLATION;
                    end else if (r_free_found) begin
                        res_status = brlt_pkg::ST_OK;
                    end else begin
                        res_status = brlt_pkg::ST_FULL;
                    end
                end
                brlt_pkg::MODE_UNLOCK: begin
                    res_status = r_match_found ? brlt_pkg::ST_OK : brlt_pkg::ST_VIOLATION;
                end
                brlt_pkg::MODE_CLOSE: begin
                    res_status = brlt_pkg::ST_OK;
                end
                default: begin
                    res_status = brlt_pkg::ST_OK;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_status <= res_status;
            r_crit   <= res_crit;
        end
    end

    // Status to the controller
    assign o_sts.addr_last = (r_addr == LAST_IDX);
    assign o_sts.quick     = r_handle_oor
                             || (r_zero_len && r_mode != brlt_pkg::MODE_CLOSE);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_critical_error = r_crit;

endmodule

// ----- design/byte_range_lock_table_top.sv -----
`timescale 1ns / 1ps
// Top level of the byte-range lock table: controller plus datapath.
// Depends on brlt_pkg, brlt_ctrl and brlt_dpath.
//
// Each request word is handled on its own: after it is taken the block reads
// every lock slot from the slot memory, one slot per cycle through its single
// read port, then writes back at most one slot; requests with a handle out of
// range, or of zero length and not close, are answered without a scan.
// Close handle frees matching slots as the scan passes them. After reset the
// block clears every slot of the slot memory and stalls input while it does
// so. A new request is taken while the previous result still waits in the
// output register.
module byte_range_lock_table_top #(
    parameter int LOCK_ENTRIES = brlt_pkg::LOCK_ENTRIES_DEF,
    parameter int HANDLE_COUNT = brlt_pkg::HANDLE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_mode,
    input  logic [brlt_pkg::OWNER_W-1:0]  i_owner,
    input  logic [brlt_pkg::HANDLE_W-1:0] i_handle,
    input  logic [brlt_pkg::KEY_W-1:0]    i_file_key,
    input  logic [brlt_pkg::OFS_W-1:0]    i_offset,
    input  logic [brlt_pkg::OFS_W-1:0]    i_length,
    input  logic                          i_raise_critical,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [1:0]                    o_status,
    output logic                          o_critical_error
);

    brlt_pkg::t_cmd cmd;
    brlt_pkg::t_sts sts;

    brlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    brlt_dpath #(
        .LOCK_ENTRIES (LOCK_ENTRIES),
        .HANDLE_COUNT (HANDLE_COUNT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_mode),
        .i_owner          (i_owner),
        .i_handle         (i_handle),
        .i_file_key       (i_file_key),
        .i_offset         (i_offset),
        .i_length         (i_length),
        .i_raise_critical (i_raise_critical),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_status         (o_status),
        .o_critical_error (o_critical_error)
    );

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the byte-range lock table: directed and random
// request words, a scoreboard class that predicts status and critical error.
// Depends on brlt_pkg and byte_range_lock_table_top.

// One request word as driven on the input ports
typedef struct packed {
    brlt_pkg::t_mode               mode;
    logic [brlt_pkg::OWNER_W-1:0]  owner;
    logic [brlt_pkg::HANDLE_W-1:0] handle;
    logic [brlt_pkg::KEY_W-1:0]    file_key;
    logic [brlt_pkg::OFS_W-1:0]    offset;
    logic [brlt_pkg::OFS_W-1:0]    length;
    logic                          raise_critical;
} t_lock_req;

// Expected answer to one request word
typedef struct packed {
    brlt_pkg::t_status status;
    logic              critical;
} t_lock_answer;

// Lock table predictor plus the queue of answers still owed by the block
class t_lock_scoreboard;
    localparam int ENTRIES = brlt_pkg::LOCK_ENTRIES_DEF;
    localparam int HANDLES = brlt_pkg::HANDLE_COUNT_DEF;

    bit                            used [ENTRIES];
    logic [brlt_pkg::OFS_W-1:0]    start_ofs [ENTRIES];
    logic [brlt_pkg::OFS_W-1:0]    end_ofs [ENTRIES];
    logic [brlt_pkg::HANDLE_W-1:0] slot_handle [ENTRIES];
    logic [brlt_pkg::OWNER_W-1:0]  slot_owner [ENTRIES];
    logic [brlt_pkg::KEY_W-1:0]    slot_key [ENTRIES];

    t_lock_answer answers_q[$];
    int errors;
    int mode_count [4];
    int status_count [3];
    int critical_count;

    function new();
        foreach (used[i]) used[i] = 1'b0;
        errors = 0;
        critical_count = 0;
        foreach (mode_count[i]) mode_count[i] = 0;
        foreach (status_count[i]) status_count[i] = 0;
    endfunction

    function int pending();
        return answers_q.size();
    endfunction

    // Any counted lock on this file sharing a byte with [lo, hi)
    function bit region_taken(logic [brlt_pkg::OWNER_W-1:0] who, bit any_owner,
                              logic [brlt_pkg::KEY_W-1:0] key,
                              logic [brlt_pkg::OFS_W-1:0] lo,
                              logic [brlt_pkg::OFS_W-1:0] hi);
        for (int i = 0; i < ENTRIES; i++) begin
            if (used[i] && (any_owner || slot_owner[i] != who) &&
                slot_key[i] == key && lo < end_ofs[i] && start_ofs[i] < hi)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one accepted request word to the table and queue its answer
    function void note_request(t_lock_req r);
        logic [brlt_pkg::OFS_W:0]   sum;
        logic [brlt_pkg::OFS_W-1:0] last;
        t_lock_answer               ans;
        sum  = {1'b0, r.offset} + {1'b0, r.length};
        last = sum[brlt_pkg::OFS_W] ? brlt_pkg::END_SAT : sum[brlt_pkg::OFS_W-1:0];
        ans.status   = brlt_pkg::ST_OK;
        ans.critical = 1'b0;
        mode_count[r.mode]++;
        if (r.mode == brlt_pkg::MODE_CLOSE) begin
            if (int'(r.handle) < HANDLES) begin
                for (int i = 0; i < ENTRIES; i++)
                    if (used[i] && slot_handle[i] == r.handle) used[i] = 1'b0;
            end
        end else if (int'(r.handle) >= HANDLES) begin
            ans.status = brlt_pkg::ST_VIOLATION;
        end else if (last == r.offset) begin
            ans.status = brlt_pkg::ST_OK;
        end else if (r.mode == brlt_pkg::MODE_ACCESS) begin
            if (region_taken(r.owner, r.owner == '0, r.file_key, r.offset, last)) begin
                ans.status   = brlt_pkg::ST_VIOLATION;
                ans.critical = r.raise_critical;
            end
        end else if (r.mode == brlt_pkg::MODE_LOCK) begin
            if (region_taken(r.owner, 1'b1, r.file_key, r.offset, last)) begin
                ans.status = brlt_pkg::ST_VIOLATION;
            end else begin
                ans.status = brlt_pkg::ST_FULL;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (!used[i]) begin
                        used[i]        = 1'b1;
                        start_ofs[i]   = r.offset;
                        end_ofs[i]     = last;
                        slot_handle[i] = r.handle;
                        slot_owner[i]  = r.owner;
                        slot_key[i]    = r.file_key;
                        ans.status     = brlt_pkg::ST_OK;
                        break;
                    end
                end
            end
        end else begin
            // unlock needs an exact match on owner, handle and region
            ans.status = brlt_pkg::ST_VIOLATION;
            for (int i = 0; i < ENTRIES; i++) begin
                if (used[i] && slot_owner[i] == r.owner && slot_handle[i] == r.handle &&
                    start_ofs[i] == r.offset && end_ofs[i] == last) begin
                    used[i]    = 1'b0;
                    ans.status = brlt_pkg::ST_OK;
                    break;
                end
            end
        end
        status_count[ans.status]++;
        if (ans.critical) critical_count++;
        answers_q.push_back(ans);
    endfunction

    // Compare one accepted result word with the oldest expected answer
    function void check_result(logic [1:0] status, logic critical);
        t_lock_answer want;
        if (answers_q.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected: status %0d critical %0b",
                     $time, status, critical);
            return;
        end
        want = answers_q.pop_front();
        if (status !== want.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status);
        end
        if (critical !== want.critical) begin
            errors++;
            $display("%0t: critical_error mismatch: expected %0b, actual %0b",
                     $time, want.critical, critical);
        end
    endfunction
endclass

module tb;
    localparam int RANDOM_WORDS = 800;
    localparam int CYCLE_LIMIT  = 600000;

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          i_in_valid       = 1'b0;
    logic                          o_in_stall;
    logic [1:0]                    i_mode           = '0;
    logic [brlt_pkg::OWNER_W-1:0]  i_owner          = '0;
    logic [brlt_pkg::HANDLE_W-1:0] i_handle         = '0;
    logic [brlt_pkg::KEY_W-1:0]    i_file_key       = '0;
    logic [brlt_pkg::OFS_W-1:0]    i_offset         = '0;
    logic [brlt_pkg::OFS_W-1:0]    i_length         = '0;
    logic                          i_raise_critical = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall      = 1'b0;
    logic [1:0]                    o_status;
    logic                          o_critical_error;

    t_lock_scoreboard sb;
    t_lock_req placed_q[$];     // recent lock words, reused for exact unlocks
    int cycles = 0;
    int stall_left = 0;
    int stall_style = 0;

    byte_range_lock_table_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_owner          (i_owner),
        .i_handle         (i_handle),
        .i_file_key       (i_file_key),
        .i_offset         (i_offset),
        .i_length         (i_length),
        .i_raise_critical (i_raise_critical),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_critical_error (o_critical_error)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check accepted words, stall in runs of changing style
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_status, o_critical_error);
            if (stall_left == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(5, 60);
            end
            stall_left--;
            case (stall_style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= 1'b1;
            endcase
        end
    end

    function automatic t_lock_req make_req(brlt_pkg::t_mode mode,
                                           logic [brlt_pkg::OWNER_W-1:0] owner,
                                           logic [brlt_pkg::HANDLE_W-1:0] handle,
                                           logic [brlt_pkg::KEY_W-1:0] key,
                                           logic [brlt_pkg::OFS_W-1:0] ofs,
                                           logic [brlt_pkg::OFS_W-1:0] len, logic crit);
        t_lock_req r;
        r.mode = mode;
        r.owner = owner;
        r.handle = handle;
        r.file_key = key;
        r.offset = ofs;
        r.length = len;
        r.raise_critical = crit;
        return r;
    endfunction

    // Mostly well-formed traffic on a few owners, handles and files so that
    // regions collide and the table fills; the rest is unconstrained noise.
    function automatic t_lock_req random_request(bit fill_phase);
        t_lock_req r;
        int roll;
        int pick;
        r.owner          = 16'($urandom_range(1, 4));
        r.handle         = 8'($urandom_range(0, 5));
        r.file_key       = 16'(32'h0100 + $urandom_range(0, 2));
        r.offset         = $urandom_range(0, 47) * 32 + $urandom_range(0, 7);
        r.length         = $urandom_range(1, 40);
        r.raise_critical = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            r.mode     = brlt_pkg::t_mode'($urandom_range(0, 3));
            r.owner    = 16'($urandom);
            r.handle   = 8'($urandom);
            r.file_key = 16'($urandom);
            r.offset   = $urandom;
            r.length   = $urandom;
            return r;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) r.length = '0;
        else if (roll < 6) begin
            r.offset = 32'hFFFF_FF00 | $urandom_range(0, 255);
            r.length = $urandom;
        end
        roll = $urandom_range(0, 99);
        if (roll < (fill_phase ? 20 : 30)) begin
            r.mode = brlt_pkg::MODE_ACCESS;
            if ($urandom_range(0, 9) == 0) r.owner = '0;
        end else if (roll < (fill_phase ? 85 : 60)) begin
            r.mode = brlt_pkg::MODE_LOCK;
            placed_q.push_back(r);
            if (placed_q.size() > 64) void'(placed_q.pop_front());
        end else if (roll < (fill_phase ? 97 : 88)) begin
            r.mode = brlt_pkg::MODE_UNLOCK;
            if (placed_q.size() > 0 && $urandom_range(0, 4) != 0) begin
                pick     = $urandom_range(0, placed_q.size() - 1);
                r.owner  = placed_q[pick].owner;
                r.handle = placed_q[pick].handle;
                r.offset = placed_q[pick].offset;
                r.length = placed_q[pick].length;
            end
        end else begin
            r.mode   = brlt_pkg::MODE_CLOSE;
            r.owner  = 16'($urandom);
            r.offset = $urandom;
            r.length = $urandom;
        end
        return r;
    endfunction

    // Drive one word and hold it until the block takes it
    task automatic send_request(input t_lock_req r);
        i_mode           <= r.mode;
        i_owner          <= r.owner;
        i_handle         <= r.handle;
        i_file_key       <= r.file_key;
        i_offset         <= r.offset;
        i_length         <= r.length;
        i_raise_critical <= r.raise_critical;
        i_in_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(r);
    endtask

    // Hold off input until every owed answer has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    initial begin
        int burst_left;
        int gap;
        sb = new();
        burst_left = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: overlap rules, enclosed lock, saturation, zero length
        send_request(make_req(brlt_pkg::MODE_ACCESS, 16'd5, 8'd1, 16'h0010, 32'd100,
                              32'd50, 1'b1));
        send_request(make_req(brlt_pkg::MODE_LOCK,   16'd5, 8'd1, 16'h0010, 32'd100,
                              32'd50, 1'b0));
        send_request(make_req(brlt_pkg::MODE_ACCESS, 16'd5, 8'd1, 16'h0010, 32'd100,
                              32'd50, 1'b1));
        send_request(make_req(brlt_pkg::MODE_ACCESS, 16'd6, 8'd2, 16'h0010, 32'd120,
                              32'd1, 1'b1));
        send_request(make_req(brlt_pkg::MODE_ACCESS, 16'd0, 8'd2, 16'h0010, 32'd140,
                              32'd20, 1'b0));
        send_request(make_req(brlt_pkg::MODE_LOCK,   16'd5, 8'd1, 16'h0010, 32'd149,
                              32'd1, 1'b0));
        send_request(make_req(brlt_pkg::MODE_LOCK,   16'd6, 8'd3, 16'h0010, 32'd150,
                              32'd10, 1'b0));
        send_request(make_req(brlt_pkg::MODE_LOCK,   16'd7, 8'd4, 16'h0010, 32'd90,
                              32'd100, 1'b0));
        send_request(make_req(brlt_pkg::MODE_LOCK,   16'd7, 8'd4, 16'h0011, 32'd90,
                              32'd100, 1'b0));
        send_request(make_req(brlt_pkg::MODE_LOCK,   16'd7, 8'd4, 16'h0010, 32'd120,
                              32'd0, 1'b0));
        send_request(make_req(brlt_pkg::MODE_UNLOCK, 16'd9, 8'd9, 16'h0010, 32'd120,
                              32'd0, 1'b0));
        send_request(make_req(brlt_pkg::MODE_UNLOCK, 16'd5, 8'd1, 16'h0010, 32'd100,
                              32'd49, 1'b0));
        send_request(make_req(brlt_pkg::MODE_UNLOCK, 16'd5, 8'd1, 16'h0010, 32'd100,
                              32'd50, 1'b0));
        send_request(make_req(brlt_pkg::MODE_LOCK,   16'd8, 8'd2, 16'hFFFF, 32'hFFFF_FFF0,
                              32'hFFFF_FFFF, 1'b0));
        send_request(make_req(brlt_pkg::MODE_ACCESS, 16'd9, 8'd2, 16'hFFFF, 32'hFFFF_FFFF,
                              32'd1, 1'b1));
        send_request(make_req(brlt_pkg::MODE_ACCESS, 16'd9, 8'd2, 16'hFFFF, 32'hFFFF_FFFE,
                              32'd5, 1'b1));
        send_request(make_req(brlt_pkg::MODE_UNLOCK, 16'd8, 8'd2, 16'hFFFF, 32'hFFFF_FFF0,
                              32'h20, 1'b0));
        send_request(make_req(brlt_pkg::MODE_ACCESS, 16'hFFFF, 8'hFF, 16'h0011, 32'd0,
                              32'hFFFF_FFFF, 1'b1));
        send_request(make_req(brlt_pkg::MODE_CLOSE,  16'hFFFF, 8'd1, 16'hFFFF, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 1'b1));
        send_request(make_req(brlt_pkg::MODE_CLOSE,  16'd0, 8'hFF, 16'd0, 32'd0,
                              32'd0, 1'b0));
        send_request(make_req(brlt_pkg::MODE_ACCESS, 16'd5, 8'd1, 16'h0010, 32'd0,
                              32'hFFFF_FFFF, 1'b1));
        send_request(make_req(brlt_pkg::MODE_CLOSE,  16'd0, 8'd4, 16'd0, 32'd0,
                              32'd0, 1'b0));
        drain_results();

        // Random words in bursts; phases alternate between filling and freeing
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) drain_results();
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                gap        = $urandom_range(0, 12);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
            send_request(random_request(((n / 100) % 2) == 0));
        end

        // Let the last answers come back, then watch for strays
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (brlt_pkg::LOCK_ENTRIES_DEF + 8) @(posedge i_clk);

        $display("Covered %0d words: %0d access, %0d lock, %0d unlock, %0d close.",
                 sb.mode_count[brlt_pkg::MODE_ACCESS] + sb.mode_count[brlt_pkg::MODE_LOCK]
                 + sb.mode_count[brlt_pkg::MODE_UNLOCK] + sb.mode_count[brlt_pkg::MODE_CLOSE],
                 sb.mode_count[brlt_pkg::MODE_ACCESS], sb.mode_count[brlt_pkg::MODE_LOCK],
                 sb.mode_count[brlt_pkg::MODE_UNLOCK], sb.mode_count[brlt_pkg::MODE_CLOSE]);
        $display("Answers: %0d ok, %0d violation, %0d table full, %0d critical error.",
                 sb.status_count[brlt_pkg::ST_OK], sb.status_count[brlt_pkg::ST_VIOLATION],
                 sb.status_count[brlt_pkg::ST_FULL], sb.critical_count);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
